@@ rtl/core/srt_pkg.sv @@
// Shared types and constants for the sorted rectangle table.
// Holds the entry layout, command and status codes, and the sequencer states.
// No dependencies.
`default_nettype none

package srt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int COORD_W     = 10;
	localparam int KEY_W       = 10;
	localparam int AREA_W      = 20;
	localparam int PERIM_W     = 12;
	localparam int TOTAL_W     = 9;
	localparam int STATUS_W    = 3;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COORD_W-1:0] EXTENT_RIGHT_RST = 10'd800;
	localparam logic [COORD_W-1:0] EXTENT_TOP_RST   = 10'd600;

	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_RIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_TOP   = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_COORD = 3'd1,
		STAT_DUPLICATE = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_SHIFT,
		S_PLACE,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COORD_W-1:0] lt;
		logic [COORD_W-1:0] rt;
		logic [COORD_W-1:0] bot;
		logic [COORD_W-1:0] tp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ rtl/core/srt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the rectangle store. No dependencies.
`default_nettype none

module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sorted_rectangle_table_top.sv @@
// Top level of the sorted rectangle table: command sequencer, key compare and shift control.
// Depends on srt_pkg and srt_ram.
`default_nettype none

// Usage
// A request is taken at a rising edge where start is high and busy is low; cmd selects
// insert, find or delete, name_key names the entry, and the four coordinates are used by
// insert only. busy stays high until the reply; exactly one reply per request appears for
// one cycle with done high, carrying status, the entry's coordinates, area, perimeter and
// the entry count after the command. The receiver cannot stall; the reply is simply shown.
// Every request that passes the early checks walks the sorted store through one read port,
// one entry a cycle, and stops at the first key that is equal or larger. An insert of a
// new key and a delete that finds its key then move each later entry by one slot, one read
// and one write a cycle. Early errors (full table, bad coordinates, empty table, unknown
// command) skip the walk and reply straight from the check. The extent registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them only while
// idle, as the block itself leaves this unchecked. Reset empties the table and loads the
// extents with 800 and 600; the store itself needs no clearing since only entries below
// the count are ever read.

module sorted_rectangle_table_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [srt_pkg::CMD_W-1:0]      cmd,
	input  wire logic [srt_pkg::KEY_W-1:0]      name_key,
	input  wire logic [srt_pkg::COORD_W-1:0]    left,
	input  wire logic [srt_pkg::COORD_W-1:0]    right,
	input  wire logic [srt_pkg::COORD_W-1:0]    bottom,
	input  wire logic [srt_pkg::COORD_W-1:0]    top,
	input  wire logic                           cfg_we,
	input  wire logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [srt_pkg::COORD_W-1:0]    cfg_data,
	output logic                                done,
	output logic      [srt_pkg::STATUS_W-1:0]   status,
	output logic      [srt_pkg::COORD_W-1:0]    found_left,
	output logic      [srt_pkg::COORD_W-1:0]    found_right,
	output logic      [srt_pkg::COORD_W-1:0]    found_bottom,
	output logic      [srt_pkg::COORD_W-1:0]    found_top,
	output logic      [srt_pkg::AREA_W-1:0]     area,
	output logic      [srt_pkg::PERIM_W-1:0]    perimeter,
	output logic      [srt_pkg::TOTAL_W-1:0]    entry_total
);

	localparam int CW = srt_pkg::CNT_W;
	localparam int IW = srt_pkg::IDX_W;
	localparam int DW = srt_pkg::COORD_W;

	// Control state
	srt_pkg::state_t          state_q, state_d;
	logic [CW-1:0]            count_q, count_d;
	logic [DW-1:0]            ext_right_q, ext_top_q;
	logic                     pend_q, pend_d;
	logic                     done_q;

	// Request and walk registers
	logic [srt_pkg::CMD_W-1:0] cmd_q, cmd_d;
	srt_pkg::entry_t           req_q, req_d;
	srt_pkg::entry_t           hit_q, hit_d;
	srt_pkg::status_t          res_q, res_d;
	logic [CW-1:0]             ridx_q, ridx_d;
	logic [CW-1:0]             pidx_q, pidx_d;
	logic [CW-1:0]             pos_q, pos_d;
	logic [CW-1:0]             rem_q, rem_d;

	// Reply registers
	logic [srt_pkg::STATUS_W-1:0] status_q;
	logic [DW-1:0]                lt_q, rt_q, bot_q, tp_q;
	logic [srt_pkg::AREA_W-1:0]   area_q;
	logic [srt_pkg::PERIM_W-1:0]  perim_q;
	logic [srt_pkg::TOTAL_W-1:0]  total_q;

	// Store port
	logic                          ram_we, ram_re;
	logic [IW-1:0]                 ram_waddr, ram_raddr;
	logic [srt_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
	srt_pkg::entry_t               rd_entry;

	// Search outcome
	logic          coord_ok;
	logic          srch_end, srch_found;
	logic [CW-1:0] srch_pos;

	// Reply datapath
	srt_pkg::entry_t         rep;
	logic [DW-1:0]           rep_w, rep_h;
	logic [DW:0]             rep_sum;
	logic [2*DW-1:0]         rep_prod;

	srt_ram #(
		.WIDTH (srt_pkg::ENTRY_W),
		.DEPTH (srt_pkg::TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = srt_pkg::entry_t'(ram_rdata);

	assign coord_ok = (req_q.lt < ext_right_q) && (req_q.rt <= ext_right_q) &&
		(req_q.rt > req_q.lt) && (req_q.bot < ext_top_q) &&
		(req_q.tp <= ext_top_q) && (req_q.tp > req_q.bot);

	// The store is sorted, so the walk stops at the first key that is not smaller.
	always_comb begin
		srch_end   = 1'b0;
		srch_found = 1'b0;
		srch_pos   = count_q;
		if (pend_q && (rd_entry.key >= req_q.key)) begin
			srch_end   = 1'b1;
			srch_found = (rd_entry.key == req_q.key);
			srch_pos   = pidx_q;
		end else if (ridx_q == count_q) begin
			srch_end = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pend_d    = pend_q;
		cmd_d     = cmd_q;
		req_d     = req_q;
		hit_d     = hit_q;
		res_d     = res_q;
		ridx_d    = ridx_q;
		pidx_d    = pidx_q;
		pos_d     = pos_q;
		rem_d     = rem_q;
		ram_we    = 1'b0;
		ram_waddr = pidx_q[IW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ridx_q[IW-1:0];

		case (state_q)
			srt_pkg::S_IDLE: begin
				if (start) begin
					cmd_d   = cmd;
					req_d   = {name_key, left, right, bottom, top};
					state_d = srt_pkg::S_CHECK;
				end
			end

			srt_pkg::S_CHECK: begin
				ridx_d  = '0;
				pend_d  = 1'b0;
				state_d = srt_pkg::S_SEARCH;
				case (cmd_q)
					srt_pkg::CMD_INSERT: begin
						if (count_q == CW'(srt_pkg::TABLE_DEPTH)) begin
							res_d   = srt_pkg::STAT_FULL;
							state_d = srt_pkg::S_REPLY;
						end else if (!coord_ok) begin
							res_d   = srt_pkg::STAT_BAD_COORD;
							state_d = srt_pkg::S_REPLY;
						end
					end
					srt_pkg::CMD_FIND: begin
					end
					srt_pkg::CMD_DELETE: begin
						if (count_q == '0) begin
							res_d   = srt_pkg::STAT_EMPTY;
							state_d = srt_pkg::S_REPLY;
						end
					end
					default: begin
						res_d   = srt_pkg::STAT_NOT_FOUND;
						state_d = srt_pkg::S_REPLY;
					end
				endcase
			end

			srt_pkg::S_SEARCH: begin
				if (srch_end) begin
					pend_d = 1'b0;
					pos_d  = srch_pos;
					hit_d  = rd_entry;
					case (cmd_q)
						srt_pkg::CMD_INSERT: begin
							if (srch_found) begin
								res_d   = srt_pkg::STAT_DUPLICATE;
								state_d = srt_pkg::S_REPLY;
							end else begin
								// Move entries at and above the slot up by one, top first.
								rem_d   = count_q - srch_pos;
								ridx_d  = count_q - CW'(1);
								state_d = srt_pkg::S_SHIFT;
							end
						end
						srt_pkg::CMD_DELETE: begin
							if (srch_found) begin
								// Move entries above the hit down by one, bottom first.
								rem_d   = count_q - srch_pos - CW'(1);
								ridx_d  = srch_pos + CW'(1);
								state_d = srt_pkg::S_SHIFT;
							end else begin
								res_d   = srt_pkg::STAT_NOT_FOUND;
								state_d = srt_pkg::S_REPLY;
							end
						end
						default: begin
							res_d   = srch_found ? srt_pkg::STAT_OK : srt_pkg::STAT_NOT_FOUND;
							state_d = srt_pkg::S_REPLY;
						end
					endcase
				end else begin
					ram_re = 1'b1;
					pend_d = 1'b1;
					pidx_d = ridx_q;
					ridx_d = ridx_q + CW'(1);
				end
			end

			srt_pkg::S_SHIFT: begin
				// A read issued last cycle lands at its destination this cycle.
				ram_we = pend_q;
				if (rem_q != '0) begin
					ram_re = 1'b1;
					pend_d = 1'b1;
					rem_d  = rem_q - CW'(1);
					if (cmd_q == srt_pkg::CMD_INSERT) begin
						pidx_d = ridx_q + CW'(1);
						ridx_d = ridx_q - CW'(1);
					end else begin
						pidx_d = ridx_q - CW'(1);
						ridx_d = ridx_q + CW'(1);
					end
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						if (cmd_q == srt_pkg::CMD_INSERT) begin
							state_d = srt_pkg::S_PLACE;
						end else begin
							count_d = count_q - CW'(1);
							res_d   = srt_pkg::STAT_OK;
							state_d = srt_pkg::S_REPLY;
						end
					end
				end
			end

			srt_pkg::S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = req_q;
				count_d   = count_q + CW'(1);
				res_d     = srt_pkg::STAT_OK;
				state_d   = srt_pkg::S_REPLY;
			end

			srt_pkg::S_REPLY: begin
				state_d = srt_pkg::S_IDLE;
			end

			default: begin
				state_d = srt_pkg::S_IDLE;
			end
		endcase
	end

	// Reply contents: the new entry for insert, the hit for find and delete, zero on error.
	always_comb begin
		if (res_q != srt_pkg::STAT_OK) begin
			rep = '0;
		end else if (cmd_q == srt_pkg::CMD_INSERT) begin
			rep = req_q;
		end else begin
			rep = hit_q;
		end
		rep_w    = rep.rt - rep.lt;
		rep_h    = rep.tp - rep.bot;
		rep_sum  = {1'b0, rep_w} + {1'b0, rep_h};
		rep_prod = {{DW{1'b0}}, rep_w} * {{DW{1'b0}}, rep_h};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srt_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			ext_right_q <= srt_pkg::EXTENT_RIGHT_RST;
			ext_top_q   <= srt_pkg::EXTENT_TOP_RST;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= (state_q == srt_pkg::S_REPLY);
			if (cfg_we) begin
				case (cfg_index)
					srt_pkg::CFG_EXTENT_RIGHT: ext_right_q <= cfg_data;
					srt_pkg::CFG_EXTENT_TOP:   ext_top_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		req_q  <= req_d;
		hit_q  <= hit_d;
		res_q  <= res_d;
		ridx_q <= ridx_d;
		pidx_q <= pidx_d;
		pos_q  <= pos_d;
		rem_q  <= rem_d;
		if (state_q == srt_pkg::S_REPLY) begin
			status_q <= res_q;
			lt_q     <= rep.lt;
			rt_q     <= rep.rt;
			bot_q    <= rep.bot;
			tp_q     <= rep.tp;
			area_q   <= srt_pkg::AREA_W'(rep_prod);
			perim_q  <= srt_pkg::PERIM_W'({rep_sum, 1'b0});
			total_q  <= srt_pkg::TOTAL_W'(count_q);
		end
	end

	assign busy         = (state_q != srt_pkg::S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign found_left   = lt_q;
	assign found_right  = rt_q;
	assign found_bottom = bot_q;
	assign found_top    = tp_q;
	assign area         = area_q;
	assign perimeter    = perim_q;
	assign entry_total  = total_q;

endmodule

`default_nettype wire

@@ tb/sorted_rectangle_table_top_tb.sv @@
// Self-checking testbench for the sorted rectangle table: directed rows, then random requests.
// Depends on srt_pkg and sorted_rectangle_table_top; every reply is checked against a predictor or a directed row.
`timescale 1ns / 1ps

module sorted_rectangle_table_top_tb;
	import srt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int KEY_POOL_SIZE = 48;
	localparam int IDLE_LIMIT = 6000;
	localparam int TAIL_CYCLES = 600;

	typedef struct packed {
		status_t              status;
		logic [COORD_W-1:0]   lt;
		logic [COORD_W-1:0]   rt;
		logic [COORD_W-1:0]   bot;
		logic [COORD_W-1:0]   tp;
		logic [AREA_W-1:0]    area;
		logic [PERIM_W-1:0]   perim;
		logic [TOTAL_W-1:0]   total;
	} reply_t;

	typedef struct packed {
		logic [CMD_W-1:0]     op;
		logic [KEY_W-1:0]     key;
		logic [COORD_W-1:0]   lt;
		logic [COORD_W-1:0]   rt;
		logic [COORD_W-1:0]   bot;
		logic [COORD_W-1:0]   tp;
		logic                 typed;
		status_t              want_status;
		logic [TOTAL_W-1:0]   want_total;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [CMD_W-1:0]      cmd = '0;
	logic [KEY_W-1:0]      name_key = '0;
	logic [COORD_W-1:0]    left = '0;
	logic [COORD_W-1:0]    right = '0;
	logic [COORD_W-1:0]    bottom = '0;
	logic [COORD_W-1:0]    top = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COORD_W-1:0]    cfg_data = '0;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [COORD_W-1:0]    found_left;
	logic [COORD_W-1:0]    found_right;
	logic [COORD_W-1:0]    found_bottom;
	logic [COORD_W-1:0]    found_top;
	logic [AREA_W-1:0]     area;
	logic [PERIM_W-1:0]    perimeter;
	logic [TOTAL_W-1:0]    entry_total;

	// Predictor state: the sorted table and the extents as the block should hold them.
	entry_t                rect_rows [TABLE_DEPTH];
	int                    rows_held = 0;
	logic [COORD_W-1:0]    lim_right = EXTENT_RIGHT_RST;
	logic [COORD_W-1:0]    lim_top = EXTENT_TOP_RST;

	reply_t                pending_replies [$];
	logic [KEY_W-1:0]      key_pool [KEY_POOL_SIZE];
	bit                    gaps_on = 1'b1;
	int                    n_requests = 0;
	int                    n_replies = 0;
	int                    n_full = 0;
	int                    n_errors = 0;
	int                    idle_cycles = 0;

	// Directed rows. Error rows carry their status and count; the rest use the predictor.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_FIND,   10'h000, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_NOT_FOUND, 9'd0},
		'{CMD_DELETE, 10'h000, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_EMPTY,     9'd0},
		'{CMD_UNUSED, 10'h3FF, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, STAT_NOT_FOUND, 9'd0},
		'{CMD_INSERT, 10'h155, 10'd5,    10'd5,    10'd0,    10'd10,   1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h155, 10'd0,    10'd801,  10'd0,    10'd10,   1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h155, 10'd0,    10'd10,   10'd0,    10'd601,  1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h155, 10'd0,    10'd10,   10'd10,   10'd10,   1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h3FF, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h155, 10'd10,   10'd5,    10'd0,    10'd10,   1'b1, STAT_BAD_COORD, 9'd0},
		'{CMD_INSERT, 10'h000, 10'd0,    10'd800,  10'd0,    10'd600,  1'b0, STAT_OK,        9'd0},
		'{CMD_INSERT, 10'h3FF, 10'd799,  10'd800,  10'd599,  10'd600,  1'b0, STAT_OK,        9'd0},
		'{CMD_INSERT, 10'h200, 10'd0,    10'd1,    10'd0,    10'd1,    1'b0, STAT_OK,        9'd0},
		'{CMD_INSERT, 10'h000, 10'd1,    10'd2,    10'd1,    10'd2,    1'b1, STAT_DUPLICATE, 9'd3},
		'{CMD_INSERT, 10'h000, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_BAD_COORD, 9'd3},
		'{CMD_FIND,   10'h200, 10'd0,    10'd0,    10'd0,    10'd0,    1'b0, STAT_OK,        9'd0},
		'{CMD_FIND,   10'h005, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_NOT_FOUND, 9'd3},
		'{CMD_DELETE, 10'h000, 10'd0,    10'd0,    10'd0,    10'd0,    1'b0, STAT_OK,        9'd0},
		'{CMD_DELETE, 10'h007, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_NOT_FOUND, 9'd2},
		'{CMD_DELETE, 10'h3FF, 10'd0,    10'd0,    10'd0,    10'd0,    1'b0, STAT_OK,        9'd0},
		'{CMD_FIND,   10'h3FF, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_NOT_FOUND, 9'd1},
		'{CMD_DELETE, 10'h200, 10'd0,    10'd0,    10'd0,    10'd0,    1'b0, STAT_OK,        9'd0},
		'{CMD_DELETE, 10'h200, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_EMPTY,     9'd0},
		'{CMD_UNUSED, 10'h000, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, STAT_NOT_FOUND, 9'd0}
	};

	sorted_rectangle_table_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.name_key     (name_key),
		.left         (left),
		.right        (right),
		.bottom       (bottom),
		.top          (top),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.status       (status),
		.found_left   (found_left),
		.found_right  (found_right),
		.found_bottom (found_bottom),
		.found_top    (found_top),
		.area         (area),
		.perimeter    (perimeter),
		.entry_total  (entry_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_slot(input logic [KEY_W-1:0] key);
		for (int i = 0; i < rows_held; i++) begin
			if (rect_rows[i].key == key)
				return i;
		end
		return -1;
	endfunction

	function automatic reply_t error_reply(input status_t st);
		reply_t rep;
		rep = '0;
		rep.status = st;
		rep.total = TOTAL_W'(rows_held);
		return rep;
	endfunction

	function automatic reply_t entry_reply(input entry_t e);
		reply_t rep;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		w = e.rt - e.lt;
		h = e.tp - e.bot;
		rep.status = STAT_OK;
		rep.lt = e.lt;
		rep.rt = e.rt;
		rep.bot = e.bot;
		rep.tp = e.tp;
		rep.area = AREA_W'(w) * AREA_W'(h);
		rep.perim = (PERIM_W'(w) + PERIM_W'(h)) << 1;
		rep.total = TOTAL_W'(rows_held);
		return rep;
	endfunction

	// Applies one request to the predicted table and returns the reply it should produce.
	function automatic reply_t table_reply(input logic [CMD_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [COORD_W-1:0] l, r, b, t);
		int slot;
		entry_t fresh;
		entry_t gone;
		fresh.key = key;
		fresh.lt = l;
		fresh.rt = r;
		fresh.bot = b;
		fresh.tp = t;
		case (op)
			CMD_INSERT: begin
				if (rows_held >= TABLE_DEPTH)
					return error_reply(STAT_FULL);
				if (!(l < lim_right && r <= lim_right && r > l &&
						b < lim_top && t <= lim_top && t > b))
					return error_reply(STAT_BAD_COORD);
				if (find_slot(key) >= 0)
					return error_reply(STAT_DUPLICATE);
				slot = rows_held;
				while (slot > 0 && rect_rows[slot-1].key > key) begin
					rect_rows[slot] = rect_rows[slot-1];
					slot--;
				end
				rect_rows[slot] = fresh;
				rows_held++;
				return entry_reply(fresh);
			end
			CMD_FIND: begin
				slot = find_slot(key);
				if (slot < 0)
					return error_reply(STAT_NOT_FOUND);
				return entry_reply(rect_rows[slot]);
			end
			CMD_DELETE: begin
				if (rows_held == 0)
					return error_reply(STAT_EMPTY);
				slot = find_slot(key);
				if (slot < 0)
					return error_reply(STAT_NOT_FOUND);
				gone = rect_rows[slot];
				for (int i = slot; i + 1 < rows_held; i++)
					rect_rows[i] = rect_rows[i+1];
				rows_held--;
				return entry_reply(gone);
			end
			default: begin
				return error_reply(STAT_NOT_FOUND);
			end
		endcase
	endfunction

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drives one request, waits for it to be taken, and records the reply it should produce.
	// With a zero gap start stays high so the next request follows back to back.
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [COORD_W-1:0] l, r, b, t, input bit typed = 1'b0,
			input status_t want_status = STAT_OK, input logic [TOTAL_W-1:0] want_total = '0);
		reply_t predicted;
		int gap;
		start <= 1'b1;
		cmd <= op;
		name_key <= key;
		left <= l;
		right <= r;
		bottom <= b;
		top <= t;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = table_reply(op, key, l, r, b, t);
		if (typed) begin
			predicted = '0;
			predicted.status = want_status;
			predicted.total = want_total;
		end
		pending_replies.push_back(predicted);
		n_requests++;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_replies.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic set_extents(input logic [COORD_W-1:0] r_edge, t_edge);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_EXTENT_RIGHT;
		cfg_data <= r_edge;
		@(posedge clk);
		cfg_index <= CFG_EXTENT_TOP;
		cfg_data <= t_edge;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_right = r_edge;
		lim_top = t_edge;
	endtask

	// Mostly coordinates that fit the current extents; the rest are raw noise.
	task automatic pick_coords(output logic [COORD_W-1:0] l, r, b, t);
		l = COORD_W'($urandom);
		r = COORD_W'($urandom);
		b = COORD_W'($urandom);
		t = COORD_W'($urandom);
		if ($urandom_range(0, 9) < 8 && lim_right != 0 && lim_top != 0) begin
			l = COORD_W'($urandom_range(0, lim_right - 1));
			r = COORD_W'($urandom_range(l + 1, lim_right));
			b = COORD_W'($urandom_range(0, lim_top - 1));
			t = COORD_W'($urandom_range(b + 1, lim_top));
		end
	endtask

	function automatic logic [KEY_W-1:0] unused_key();
		logic [KEY_W-1:0] key;
		do key = KEY_W'($urandom); while (find_slot(key) >= 0);
		return key;
	endfunction

	task automatic random_request();
		logic [CMD_W-1:0] op;
		logic [KEY_W-1:0] key;
		logic [COORD_W-1:0] l, r, b, t;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			op = CMD_INSERT;
		else if (roll < 70)
			op = CMD_FIND;
		else if (roll < 95)
			op = CMD_DELETE;
		else
			op = CMD_UNUSED;
		// Finds and deletes hit a stored name about half the time.
		if (op != CMD_INSERT && rows_held > 0 && $urandom_range(0, 1) == 0)
			key = rect_rows[$urandom_range(0, rows_held - 1)].key;
		else if ($urandom_range(0, 3) != 0)
			key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		else
			key = KEY_W'($urandom);
		pick_coords(l, r, b, t);
		send_request(op, key, l, r, b, t);
	endtask

	// Keeps the table at or near its limit so full-table replies and last-slot shifts occur.
	task automatic churn_near_full();
		logic [COORD_W-1:0] l, r, b, t;
		int roll;
		roll = $urandom_range(0, 99);
		pick_coords(l, r, b, t);
		if (roll < 50)
			send_request(CMD_INSERT, unused_key(), l, r, b, t);
		else if (roll < 80)
			send_request(CMD_DELETE, rect_rows[$urandom_range(0, rows_held - 1)].key,
				l, r, b, t);
		else if (roll < 90)
			send_request(CMD_INSERT, rect_rows[$urandom_range(0, rows_held - 1)].key,
				l, r, b, t);
		else
			send_request(CMD_FIND, rect_rows[$urandom_range(0, rows_held - 1)].key,
				l, r, b, t);
	endtask

	task automatic check_field(input string field, input logic [AREA_W-1:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				$error("reply with no request waiting, status %0d", status);
				n_errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("status", AREA_W'(want.status), AREA_W'(status));
				check_field("found_left", AREA_W'(want.lt), AREA_W'(found_left));
				check_field("found_right", AREA_W'(want.rt), AREA_W'(found_right));
				check_field("found_bottom", AREA_W'(want.bot), AREA_W'(found_bottom));
				check_field("found_top", AREA_W'(want.tp), AREA_W'(found_top));
				check_field("area", want.area, area);
				check_field("perimeter", AREA_W'(want.perim), AREA_W'(perimeter));
				check_field("entry_total", AREA_W'(want.total), AREA_W'(entry_total));
				n_replies++;
				if (want.status == STAT_FULL)
					n_full++;
			end
		end
	end

	// Ends the run if neither a request, a reply nor a register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1 || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < KEY_POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset extents first, then each register is swept through several settings.
		for (int i = 0; i < DIR_ROWS; i++)
			send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].lt, dir_rows[i].rt,
				dir_rows[i].bot, dir_rows[i].tp, dir_rows[i].typed,
				dir_rows[i].want_status, dir_rows[i].want_total);

		set_extents(COORD_W'($urandom_range(100, 900)), COORD_W'($urandom_range(100, 900)));
		for (int i = 0; i < 180; i++) begin
			if (i == 90)
				wait_drained();
			random_request();
		end

		// Fill to the limit back to back, then work around the full table.
		set_extents(10'd1023, 10'd1023);
		gaps_on = 1'b0;
		while (rows_held < TABLE_DEPTH) begin
			logic [COORD_W-1:0] l, r, b, t;
			pick_coords(l, r, b, t);
			send_request(CMD_INSERT, unused_key(), l, r, b, t);
		end
		gaps_on = 1'b1;
		for (int i = 0; i < 40; i++)
			churn_near_full();

		set_extents(10'd1, 10'd1);
		for (int i = 0; i < 60; i++)
			random_request();

		set_extents(10'd0, 10'd0);
		for (int i = 0; i < 12; i++)
			random_request();

		set_extents(EXTENT_RIGHT_RST, EXTENT_TOP_RST);
		for (int i = 0; i < 80; i++)
			random_request();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d requests and %0d checked replies, %0d of them table-full.",
			n_requests, n_replies, n_full);
		$display("Extents went from reset values through random, 1023, 1 and 0 and back.");
		if (n_errors == 0 && pending_replies.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/sorted_rectangle_table_top.sv
tb/sorted_rectangle_table_top_tb.sv
